// ===== hdl/assert_macros.svh =====
// Assertion macros for the pairwise distance sort unit.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hdl/pds_pkg.sv =====
// Package for the pairwise distance sort unit: sizes, types, states.
// No dependencies.
`timescale 1ns / 1ps
package pds_pkg;
   localparam int MAX_POINTS = 10;
   localparam int NUM_PAIRS  = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int PAIR_W     = $clog2(NUM_PAIRS);
   localparam int HCNT_W     = $clog2(NUM_PAIRS + 1);
   localparam int COORD_W    = 16;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int KEY_W      = SQ_W + 2;
   localparam int FRAC_SH    = 16;
   localparam int SQ_IN_W    = KEY_W + FRAC_SH;
   localparam int DIST_W     = SQ_IN_W / 2;
   localparam int REM_W      = DIST_W + 2;
   localparam int STEP_W     = $clog2(DIST_W);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [KEY_W-1:0] key;
   } pair_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

   typedef enum logic [3:0] {
      S_LOAD, S_RDA, S_RDB, S_LATB, S_DIST, S_INS_CHK, S_INS_CMP, S_NEXT,
      S_OUT_RD, S_OUT_PA, S_OUT_PB, S_OUT_SQ, S_SQRT, S_EMIT
   } state_type;
endpackage

// ===== hdl/pds_req_if.sv =====
// Input channel: one point per transfer.
// Depends on pds_pkg.
`timescale 1ns / 1ps
interface pds_req_if import pds_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic                      last_point;
   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

// ===== hdl/pds_rsp_if.sv =====
// Result channel: one pair and its distance per transfer.
// Depends on pds_pkg.
`timescale 1ns / 1ps
interface pds_rsp_if import pds_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] first_x;
   logic signed [COORD_W-1:0] first_y;
   logic signed [COORD_W-1:0] first_z;
   logic signed [COORD_W-1:0] second_x;
   logic signed [COORD_W-1:0] second_y;
   logic signed [COORD_W-1:0] second_z;
   logic [DIST_W-1:0]         distance;
   logic                      last_pair;
   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   distance, last_pair, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 distance, last_pair, output ready);
endinterface

// ===== hdl/pds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/pds_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on pds_pkg.
`timescale 1ns / 1ps
module pds_isqrt import pds_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SQ_IN_W-1:0] value,
   output logic [DIST_W-1:0]  result,
   output sqrt_stat_type      stat
);
   logic [SQ_IN_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIST_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [REM_W-1:0]   rem_sh;
   logic [REM_W-1:0]   trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
      trial   = {root_ff[DIST_W-1:0], 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SQ_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIST_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign result    = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

// ===== hdl/pairwise_distance_sort_unit.sv =====
// Top level of the pairwise distance sort unit: sequencer, shared squarer,
// point and pair memories. Depends on pds_pkg, the channel interfaces,
// pds_ram, pds_isqrt and assert_macros.svh.
//
//  channel | direction | transfer moves
//  req     | in        | one point, last_point starts the pair work
//  rsp     | out       | one pair, its distance and last_pair
//
// Loading takes one req transfer per point. After the last point the
// shared squarer sums each pair's squared distance over x, y and z, and
// insertion sort places the pair in the pair memory, moving each smaller
// entry one place on. Each result then passes the memory reads, the
// 25-step root and the transfer, one result at a time, as set by the single
// read port and the bit-serial root. req is ready only while loading; rsp
// stalls simply hold the result. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pairwise_distance_sort_unit import pds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pds_req_if.sink    req_chan,
   pds_rsp_if.source  rsp_chan
);
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [HCNT_W-1:0]  h_ff, h_in;
   logic [PAIR_W-1:0]  p_ff, p_in, k_ff, k_in;
   logic [1:0]         comp_ff, comp_in;
   point_type          pa_ff, pa_in, pb_ff, pb_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   pair_type           ent_ff, ent_in;
   point_type          outa_ff, outa_in, outb_ff, outb_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               lastp_ff, lastp_in;

   logic               pt_we;
   logic [IDX_W-1:0]   pt_raddr;
   point_type          pt_wdata, pt_rdata;
   logic               pr_we;
   logic [PAIR_W-1:0]  pr_waddr, pr_raddr;
   pair_type           pr_wdata, pr_rdata;
   logic [KEY_W+IDX_W*2-1:0] pr_rdata_raw;
   logic [3*COORD_W-1:0]     pt_rdata_raw;
   logic               sq_start;
   logic [DIST_W-1:0]  sq_result;
   sqrt_stat_type      sq_stat;

   logic               req_xfer, rsp_xfer;
   logic               room;
   logic [CNT_W-1:0]   count_next;
   pair_type           new_ent;
   logic signed [COORD_W-1:0] ca, cb;
   logic signed [COORD_W:0]   diff;
   logic [COORD_W-1:0]        mag;
   logic               more_j, more_i, last_k;

   assign req_xfer   = req_chan.valid & req_chan.ready;
   assign rsp_xfer   = rsp_chan.valid & rsp_chan.ready;
   assign room       = count_ff < CNT_W'(MAX_POINTS);
   assign count_next = count_ff + CNT_W'(room);
   assign new_ent    = '{a: i_ff, b: j_ff, key: key_ff};
   assign more_j     = (CNT_W'(j_ff) + CNT_W'(1)) < count_ff;
   assign more_i     = (CNT_W'(i_ff) + CNT_W'(2)) < count_ff;
   assign last_k     = (HCNT_W'(k_ff) + HCNT_W'(1)) == h_ff;
   assign pt_wdata   = '{x: req_chan.point_x, y: req_chan.point_y, z: req_chan.point_z};
   assign pt_rdata   = point_type'(pt_rdata_raw);
   assign pr_rdata   = pair_type'(pr_rdata_raw);

   pds_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (pt_wdata),
      .raddr (pt_raddr),
      .rdata (pt_rdata_raw)
   );

   pds_ram #(.WIDTH(KEY_W + 2 * IDX_W), .DEPTH(NUM_PAIRS)) u_pair_ram (
      .clock (clock),
      .we    (pr_we),
      .waddr (pr_waddr),
      .wdata (pr_wdata),
      .raddr (pr_raddr),
      .rdata (pr_rdata_raw)
   );

   pds_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .value  ({ent_ff.key, FRAC_SH'(0)}),
      .result (sq_result),
      .stat   (sq_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_xfer && req_chan.last_point && count_next >= CNT_W'(2)) begin
               state_in = S_RDA;
            end
         end
         S_RDA:     state_in = S_RDB;
         S_RDB:     state_in = S_LATB;
         S_LATB:    state_in = S_DIST;
         S_DIST:    if (comp_ff == 2'd3) state_in = S_INS_CHK;
         S_INS_CHK: state_in = (p_ff == '0) ? S_NEXT : S_INS_CMP;
         S_INS_CMP: state_in = (pr_rdata.key < key_ff) ? S_INS_CHK : S_NEXT;
         S_NEXT:    state_in = (more_j || more_i) ? S_RDA : S_OUT_RD;
         S_OUT_RD:  state_in = S_OUT_PA;
         S_OUT_PA:  state_in = S_OUT_PB;
         S_OUT_PB:  state_in = S_OUT_SQ;
         S_OUT_SQ:  state_in = S_SQRT;
         S_SQRT:    if (sq_stat.done) state_in = S_EMIT;
         S_EMIT: begin
            if (rsp_xfer) begin
               state_in = last_k ? S_LOAD : S_OUT_RD;
            end
         end
         default:   state_in = S_LOAD;
      endcase
   end

   // memory and unit controls
   always_comb begin
      req_chan.ready = (state_ff == S_LOAD);
      rsp_chan.valid = (state_ff == S_EMIT);
      pt_we    = 1'b0;
      pt_raddr = i_ff;
      pr_we    = 1'b0;
      pr_waddr = p_ff;
      pr_wdata = new_ent;
      pr_raddr = k_ff;
      sq_start = 1'b0;
      unique case (state_ff)
         S_LOAD:    pt_we = req_chan.valid & room;
         S_RDB:     pt_raddr = j_ff;
         S_INS_CHK: begin
            pr_raddr = p_ff - 1'b1;
            pr_we    = (p_ff == '0);
         end
         S_INS_CMP: begin
            pr_we = 1'b1;
            // shift the smaller entry down one place, else drop the new one in
            if (pr_rdata.key < key_ff) pr_wdata = pr_rdata;
         end
         S_OUT_PA:  pt_raddr = pr_rdata.a;
         S_OUT_PB:  pt_raddr = ent_ff.b;
         S_OUT_SQ:  sq_start = 1'b1;
         default: begin
         end
      endcase
   end

   // shared squarer input
   always_comb begin
      case (comp_ff)
         2'd0:    begin ca = pa_ff.x; cb = pb_ff.x; end
         2'd1:    begin ca = pa_ff.y; cb = pb_ff.y; end
         default: begin ca = pa_ff.z; cb = pb_ff.z; end
      endcase
      diff = (COORD_W + 1)'(ca) - (COORD_W + 1)'(cb);
      mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
   end

   // datapath next values
   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      h_in     = h_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      comp_in  = comp_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      sq_in    = sq_ff;
      key_in   = key_ff;
      ent_in   = ent_ff;
      outa_in  = outa_ff;
      outb_in  = outb_ff;
      dist_in  = dist_ff;
      lastp_in = lastp_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               count_in = count_next;
               if (req_chan.last_point) begin
                  if (count_next < CNT_W'(2)) count_in = '0;
                  i_in = '0;
                  j_in = IDX_W'(1);
                  h_in = '0;
               end
            end
         end
         S_RDB:  pa_in = pt_rdata;
         S_LATB: begin
            pb_in   = pt_rdata;
            comp_in = '0;
         end
         S_DIST: begin
            sq_in   = mag * mag;
            key_in  = (comp_ff == 2'd0) ? '0 : key_ff + KEY_W'(sq_ff);
            comp_in = comp_ff + 1'b1;
            p_in    = PAIR_W'(h_ff);
         end
         S_INS_CMP: begin
            if (pr_rdata.key < key_ff) p_in = p_ff - 1'b1;
         end
         S_NEXT: begin
            h_in = h_ff + 1'b1;
            k_in = '0;
            if (more_j) begin
               j_in = j_ff + 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + IDX_W'(2);
            end
         end
         S_OUT_PA: ent_in  = pr_rdata;
         S_OUT_PB: outa_in = pt_rdata;
         S_OUT_SQ: outb_in = pt_rdata;
         S_SQRT: begin
            dist_in  = sq_result;
            lastp_in = last_k;
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               k_in = k_ff + 1'b1;
               if (last_k) count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      h_ff     <= h_in;
      p_ff     <= p_in;
      k_ff     <= k_in;
      comp_ff  <= comp_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      sq_ff    <= sq_in;
      key_ff   <= key_in;
      ent_ff   <= ent_in;
      outa_ff  <= outa_in;
      outb_ff  <= outb_in;
      dist_ff  <= dist_in;
      lastp_ff <= lastp_in;
   end

   assign rsp_chan.first_x   = outa_ff.x;
   assign rsp_chan.first_y   = outa_ff.y;
   assign rsp_chan.first_z   = outa_ff.z;
   assign rsp_chan.second_x  = outb_ff.x;
   assign rsp_chan.second_y  = outb_ff.y;
   assign rsp_chan.second_z  = outb_ff.z;
   assign rsp_chan.distance  = dist_ff;
   assign rsp_chan.last_pair = lastp_ff;

   `ASSERT_NEVER(a_one_side, clock, reset, req_chan.ready && rsp_chan.valid)
   `ASSERT_CLK(a_sqrt_state, clock, reset, sq_stat.busy |-> state_ff == S_SQRT)
   `ASSERT_CLK(a_count_cap, clock, reset, count_ff <= CNT_W'(MAX_POINTS))
endmodule
